@@ design/btenf_pkg.sv @@
// Package for the body-to-ENU net force unit: payload types, CORDIC table,
// fixed-point constants and rounding helpers. No dependencies.
`default_nettype none
package btenf_pkg;

    localparam int TrigBits    = 16;
    localparam int CordicSteps = 30;
    localparam int TrigW       = TrigBits + 2;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic [1:0] RegMass    = 2'd0;
    localparam logic [1:0] RegGravity = 2'd1;
    localparam logic [1:0] RegDamping = 2'd2;

    typedef struct packed {
        logic signed [31:0] thrust_x_body;
        logic signed [31:0] thrust_y_body;
        logic signed [31:0] thrust_z_body;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [31:0] vel_east;
        logic signed [31:0] vel_north;
        logic signed [31:0] vel_up;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_east;
        logic signed [31:0] force_north;
        logic signed [31:0] force_up;
    } t_out_item;

    // Arctangent of 2^-i as a 32-bit binary angle fraction in Q30 terms.
    function automatic logic signed [33:0] atan_lut(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
            27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

    // Round half up then clamp a Q30 CORDIC output to +-2^TrigBits.
    function automatic logic signed [TrigW-1:0] trig_out(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + (34'sd1 <<< (29 - TrigBits))) >>> (30 - TrigBits);
        if (r > (34'sd1 <<< TrigBits))       return TrigW'(1 << TrigBits);
        else if (r < -(34'sd1 <<< TrigBits)) return -TrigW'(1 << TrigBits);
        else                                 return r[TrigW-1:0];
    endfunction

    // Product of two trig values reduced back to Q.TrigBits.
    function automatic logic signed [TrigW-1:0] mul_t(input logic signed [TrigW-1:0] a,
                                                      input logic signed [TrigW-1:0] b);
        logic signed [2*TrigW-1:0] p;
        p = a * b + (2*TrigW)'(1 << (TrigBits - 1));
        return TrigW'(p >>> TrigBits);
    endfunction

endpackage
`default_nettype wire

@@ design/body_to_enu_net_force_unit.sv @@
// Body-to-ENU net force unit: the top level and its whole datapath.
// Depends on btenf_pkg.
// Stages: 31 CORDIC stages for the fold and 30 iterations, five trig,
// matrix and sum stages, one output stage.
// Throughput: one item a cycle; the pipeline advances whenever the
// output register is free or taken.
// Reset clears all valid bits and loads the register reset values.
`default_nettype none
module body_to_enu_net_force_unit import btenf_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int NStages = CordicSteps + 7;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] a;
        logic               neg;
    } t_cordic;

    typedef struct packed {
        logic signed [31:0] tx, ty, tz;
        logic signed [31:0] ve, vn, vu;
    } t_side;

    logic [31:0] r_mass, r_grav, r_damp;
    logic [NStages-1:0] r_vld;
    logic adv;

    // The whole pipeline moves together; it stalls only on a held result.
    assign adv     = !r_vld[NStages-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NStages-1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= 32'd65536;
            r_grav <= 32'd642690;
            r_damp <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegMass:    r_mass <= i_cfg_data;
                RegGravity: r_grav <= i_cfg_data;
                RegDamping: r_damp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NStages-2:0], i_valid};
        end
    end

    // Angle fold into [-90, 90] degrees; cosine is negated when folded.
    function automatic t_cordic fold(input logic signed [15:0] ang);
        t_cordic c;
        logic signed [33:0] a;
        a = 34'(ang) <<< 16;
        c.neg = 1'b0;
        if (a > (34'sd1 <<< 30)) begin
            a = (34'sd1 <<< 31) - a;
            c.neg = 1'b1;
        end else if (a < -(34'sd1 <<< 30)) begin
            a = -(34'sd1 <<< 31) - a;
            c.neg = 1'b1;
        end
        c.x = CordicGain;
        c.y = '0;
        c.a = a;
        return c;
    endfunction

    function automatic t_cordic rot(input t_cordic c, input int i);
        t_cordic o;
        o = c;
        if (c.a >= 0) begin
            o.x = c.x - (c.y >>> i);
            o.y = c.y + (c.x >>> i);
            o.a = c.a - atan_lut(i);
        end else begin
            o.x = c.x + (c.y >>> i);
            o.y = c.y - (c.x >>> i);
            o.a = c.a + atan_lut(i);
        end
        return o;
    endfunction

    // Stage 0 folds, stages 1..30 run one CORDIC iteration each.
    t_cordic r_cz [CordicSteps+1];
    t_cordic r_cy [CordicSteps+1];
    t_cordic r_cx [CordicSteps+1];
    t_side   r_sd [CordicSteps+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cz[0] <= fold(i_data.yaw_angle);
            r_cy[0] <= fold(i_data.pitch_angle);
            r_cx[0] <= fold(i_data.roll_angle);
            r_sd[0] <= '{i_data.thrust_x_body, i_data.thrust_y_body, i_data.thrust_z_body,
                         i_data.vel_east, i_data.vel_north, i_data.vel_up};
            for (int i = 0; i < CordicSteps; i++) begin
                r_cz[i+1] <= rot(r_cz[i], i);
                r_cy[i+1] <= rot(r_cy[i], i);
                r_cx[i+1] <= rot(r_cx[i], i);
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    // Stage A: trig outputs rounded and clamped.
    logic signed [TrigW-1:0] r_czv, r_szv, r_cyv, r_syv, r_cxv, r_sxv;
    t_side r_sda;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_czv <= trig_out(r_cz[CordicSteps].neg ? -r_cz[CordicSteps].x
                                                    : r_cz[CordicSteps].x);
            r_szv <= trig_out(r_cz[CordicSteps].y);
            r_cyv <= trig_out(r_cy[CordicSteps].neg ? -r_cy[CordicSteps].x
                                                    : r_cy[CordicSteps].x);
            r_syv <= trig_out(r_cy[CordicSteps].y);
            r_cxv <= trig_out(r_cx[CordicSteps].neg ? -r_cx[CordicSteps].x
                                                    : r_cx[CordicSteps].x);
            r_sxv <= trig_out(r_cx[CordicSteps].y);
            r_sda <= r_sd[CordicSteps];
        end
    end

    // Stage B: pairwise products.
    logic signed [TrigW-1:0] r_czsy, r_szsy, r_czcy, r_szcy, r_szcx, r_szsx;
    logic signed [TrigW-1:0] r_czcx, r_czsx, r_cysx, r_cycx, r_syb, r_sxb, r_cxb;
    t_side r_sdb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_czsy <= mul_t(r_czv, r_syv);
            r_szsy <= mul_t(r_szv, r_syv);
            r_czcy <= mul_t(r_czv, r_cyv);
            r_szcy <= mul_t(r_szv, r_cyv);
            r_szcx <= mul_t(r_szv, r_cxv);
            r_szsx <= mul_t(r_szv, r_sxv);
            r_czcx <= mul_t(r_czv, r_cxv);
            r_czsx <= mul_t(r_czv, r_sxv);
            r_cysx <= mul_t(r_cyv, r_sxv);
            r_cycx <= mul_t(r_cyv, r_cxv);
            r_syb  <= r_syv;
            r_sxb  <= r_sxv;
            r_cxb  <= r_cxv;
            r_sdb  <= r_sda;
        end
    end

    // Stage C: matrix elements.
    localparam int MW = TrigW + 1;
    logic signed [MW-1:0] r_m [9];
    t_side r_sdc;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m[0] <= MW'(r_czcy);
            r_m[1] <= MW'(mul_t(r_czsy, r_sxb)) - MW'(r_szcx);
            r_m[2] <= MW'(mul_t(r_czsy, r_cxb)) + MW'(r_szsx);
            r_m[3] <= MW'(r_szcy);
            r_m[4] <= MW'(mul_t(r_szsy, r_sxb)) + MW'(r_czcx);
            r_m[5] <= MW'(mul_t(r_szsy, r_cxb)) - MW'(r_czsx);
            r_m[6] <= -MW'(r_syb);
            r_m[7] <= MW'(r_cysx);
            r_m[8] <= MW'(r_cycx);
            r_sdc  <= r_sdb;
        end
    end

    // Stage D: element-by-thrust products, damping products and gravity.
    localparam int PW = MW + 32;
    logic signed [PW-1:0] r_p [9];
    logic signed [64:0]   r_dmp [3];
    logic [63:0]          r_gp;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_p[3*k]   <= r_m[3*k]   * r_sdc.tx;
                r_p[3*k+1] <= r_m[3*k+1] * r_sdc.ty;
                r_p[3*k+2] <= r_m[3*k+2] * r_sdc.tz;
            end
            r_dmp[0] <= $signed({1'b0, r_damp}) * r_sdc.ve;
            r_dmp[1] <= $signed({1'b0, r_damp}) * r_sdc.vn;
            r_dmp[2] <= $signed({1'b0, r_damp}) * r_sdc.vu;
            r_gp     <= r_mass * r_grav;
        end
    end

    // Stage E: row sums and rounding of each term.
    localparam int SW = PW + 2;
    logic signed [SW-TrigBits-1:0] r_t [3];
    logic signed [49:0]            r_d [3];
    logic signed [49:0]            r_g;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= (SW-TrigBits)'((SW'(r_p[3*k]) + SW'(r_p[3*k+1])
                                          + SW'(r_p[3*k+2])
                                          + SW'(1 << (TrigBits - 1))) >>> TrigBits);
                r_d[k] <= 50'((r_dmp[k] + 65'sd32768) >>> 16);
            end
            r_g <= $signed({2'b00, 48'((r_gp + 64'd32768) >> 16)});
        end
    end

    // Stage F: net sums and saturation into the output register.
    function automatic logic signed [31:0] sat(input logic signed [51:0] v);
        if (v > 52'sh7FFFFFFF)       return 32'sh7FFFFFFF;
        else if (v < -52'sh80000000) return -32'sh80000000;
        else                         return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_data.force_east  <= sat(52'(r_t[0]) - 52'(r_d[0]));
            o_data.force_north <= sat(52'(r_t[1]) - 52'(r_d[1]));
            o_data.force_up    <= sat(52'(r_t[2]) - 52'(r_d[2]) - 52'(r_g));
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_body_to_enu_net_force_unit.sv @@
// Self-checking testbench for the body-to-ENU net force unit: a predictor
// of the CORDIC rotation, gravity and damping, with random stimulus and stalls.
// Depends on btenf_pkg and body_to_enu_net_force_unit.
`default_nettype none
module tb_body_to_enu_net_force_unit;
    import btenf_pkg::*;

    localparam int NumRandom = 1250;
    localparam int Latency   = 37;
    localparam longint CycleLimit = 400000;

    // The scoreboard predicts each item's net force and checks results in order.
    class force_scoreboard;
        logic [31:0] mass_q, grav_q, damp_q;
        t_out_item   pending[$];
        int          errors;

        function new();
            mass_q = 32'd65536;
            grav_q = 32'd642690;
            damp_q = 32'd0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                RegMass:    mass_q = val;
                RegGravity: grav_q = val;
                RegDamping: damp_q = val;
                default: ;
            endcase
        endfunction

        static function longint fshr(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rshr(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        static function longint clamp_t(longint v);
            longint lim;
            lim = 64'sd1 <<< TrigBits;
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Sine and cosine of a binary angle by rotation-mode CORDIC.
        static function void sin_cos(logic signed [15:0] ang, output longint c,
                                     output longint s);
            longint a, x, y, nx;
            bit neg;
            a = longint'(ang) * 65536;
            x = 652032874;
            y = 0;
            neg = 0;
            if (a > (64'sd1 <<< 30)) begin
                a = (64'sd1 <<< 31) - a;
                neg = 1;
            end else if (a < -(64'sd1 <<< 30)) begin
                a = -(64'sd1 <<< 31) - a;
                neg = 1;
            end
            for (int i = 0; i < CordicSteps; i++) begin
                if (a >= 0) begin
                    nx = x - fshr(y, i);
                    y = y + fshr(x, i);
                    a -= longint'(atan_lut(i));
                end else begin
                    nx = x + fshr(y, i);
                    y = y - fshr(x, i);
                    a += longint'(atan_lut(i));
                end
                x = nx;
            end
            if (neg) x = -x;
            c = clamp_t(rshr(x, 30 - TrigBits));
            s = clamp_t(rshr(y, 30 - TrigBits));
        endfunction

        static function longint tmul(longint a, longint b);
            return rshr(a * b, TrigBits);
        endfunction

        static function logic [31:0] sat32(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function void note_input(t_in_item d);
            longint cz, sz, cy, sy, cx, sx, czsy, szsy, grav;
            longint m[3][3];
            longint thr[3], vel[3], f[3];
            t_out_item r;
            sin_cos(d.yaw_angle, cz, sz);
            sin_cos(d.pitch_angle, cy, sy);
            sin_cos(d.roll_angle, cx, sx);
            czsy = tmul(cz, sy);
            szsy = tmul(sz, sy);
            m[0][0] = tmul(cz, cy);
            m[0][1] = tmul(czsy, sx) - tmul(sz, cx);
            m[0][2] = tmul(czsy, cx) + tmul(sz, sx);
            m[1][0] = tmul(sz, cy);
            m[1][1] = tmul(szsy, sx) + tmul(cz, cx);
            m[1][2] = tmul(szsy, cx) - tmul(cz, sx);
            m[2][0] = -sy;
            m[2][1] = tmul(cy, sx);
            m[2][2] = tmul(cy, cx);
            thr = '{longint'(d.thrust_x_body), longint'(d.thrust_y_body),
                    longint'(d.thrust_z_body)};
            vel = '{longint'(d.vel_east), longint'(d.vel_north), longint'(d.vel_up)};
            for (int k = 0; k < 3; k++)
                f[k] = rshr(m[k][0] * thr[0] + m[k][1] * thr[1] + m[k][2] * thr[2],
                            TrigBits);
            grav = longint'((64'(mass_q) * 64'(grav_q) + 64'h8000) >> 16);
            f[2] -= grav;
            for (int k = 0; k < 3; k++)
                f[k] -= rshr(longint'({1'b0, damp_q}) * vel[k], 16);
            r.force_east  = sat32(f[0]);
            r.force_north = sat32(f[1]);
            r.force_up    = sat32(f[2]);
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.force_east !== want.force_east) begin
                $display("%0t: force_east expected %h actual %h", $time,
                         want.force_east, got.force_east);
                errors++;
            end
            if (got.force_north !== want.force_north) begin
                $display("%0t: force_north expected %h actual %h", $time,
                         want.force_north, got.force_north);
                errors++;
            end
            if (got.force_up !== want.force_up) begin
                $display("%0t: force_up expected %h actual %h", $time,
                         want.force_up, got.force_up);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    force_scoreboard sb = new();
    longint cycle_count = 0;
    bit stim_done = 0;

    body_to_enu_net_force_unit uut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid, .i_ready, .o_data, .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Accepted items are noted and results checked at the rising edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_data);
            if (o_valid && i_ready) sb.check_result(o_data);
        end
        if (cycle_count > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls at random, with quiet stretches of no stalling.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cycle_count % 3000 < 400) i_ready <= 1'b1;
            else begin
                g = gap_len();
                if (g == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(t_in_item d, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (Latency + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(0, 32'h0008_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h4000;
            3: return 16'hC000;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item d;
        d.thrust_x_body = rand_word();
        d.thrust_y_body = rand_word();
        d.thrust_z_body = rand_word();
        d.yaw_angle     = rand_angle();
        d.pitch_angle   = rand_angle();
        d.roll_angle    = rand_angle();
        d.vel_east      = rand_word();
        d.vel_north     = rand_word();
        d.vel_up        = rand_word();
        return d;
    endfunction

    // Stimulus: directed corners, then phases of random items under new settings.
    initial begin
        t_in_item d;
        logic [15:0] angs[6];
        angs = '{16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0000, 16'h2000};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset register values, each angle corner on every axis.
        for (int k = 0; k < 6; k++) begin
            d = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, angs[k], angs[5 - k],
                  angs[(k + 2) % 6], 32'h0001_0000, 32'hFFFF_0000, 32'h0};
            send_item(d, 0);
        end
        // Thrust at both ends of its range.
        d = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 16'h0, 16'h0,
              32'h0, 32'h0, 32'h0};
        send_item(d, 0);
        d = '{32'h80000000, 32'h80000000, 32'h80000000, 16'h2000, 16'hE000, 16'h1000,
              32'h0, 32'h0, 32'h0};
        send_item(d, 0);
        wait_drain();

        // Extreme register settings, including a write to an unused index.
        write_reg(RegMass, 32'hFFFFFFFF);
        write_reg(RegGravity, 32'hFFFFFFFF);
        write_reg(RegDamping, 32'hFFFFFFFF);
        write_reg(2'd3, 32'h1234_5678);
        for (int k = 0; k < 6; k++) send_item(rand_item(), 0);
        d = '{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
              32'h7FFFFFFF, 32'h80000000, 32'h0};
        send_item(d, 0);
        wait_drain();
        write_reg(RegMass, 32'd0);
        write_reg(RegGravity, 32'd0);
        write_reg(RegDamping, 32'd0);
        for (int k = 0; k < 6; k++) send_item(rand_item(), 0);
        wait_drain();

        // Random phases; the drain between phases holds the sender back.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(RegMass, rand_reg());
            write_reg(RegGravity, rand_reg());
            write_reg(RegDamping, rand_reg());
            for (int n = 0; n < NumRandom / 10; n++)
                send_item(rand_item(), (n % 60) < 20);
            wait_drain();
        end
        stim_done = 1;
    end

    // Final verdict once stimulus is done and everything has drained.
    initial begin
        wait (stim_done);
        repeat (Latency + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
